>>> src/fibmp_pkg.sv
package fibmp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int INDEX_BITS = 31;
  localparam int CNT_BITS   = $clog2(INDEX_BITS);

  // which product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_BX
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t op;
  } cmd_t;

endpackage

>>> src/fibmp_ctrl.sv
module fibmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output fibmp_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ_A = 4'b0010,
    S_SQ_B = 4'b0100,
    S_SQ_X = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [fibmp_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    cmd.load      = 1'b0;
    cmd.op        = fibmp_pkg::MUL_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = fibmp_pkg::CNT_BITS'(fibmp_pkg::INDEX_BITS - 1);
          state_nxt = S_SQ_A;
        end
      end
      S_SQ_A: begin
        cmd.op    = fibmp_pkg::MUL_AA;
        state_nxt = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.op    = fibmp_pkg::MUL_BB;
        state_nxt = S_SQ_X;
      end
      S_SQ_X: begin
        cmd.op = fibmp_pkg::MUL_BX;
        // last index bit done, result lands in the value register
        if (cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_SQ_A;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while busy");

  a_start_begins: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_SQ_A && cnt_r ==
      fibmp_pkg::CNT_BITS'(fibmp_pkg::INDEX_BITS - 1))
    else $error("accepted item did not start the bit loop");

  a_last_bit_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ_X && cnt_r == '0) |=> out_valid_r)
    else $error("no result after last index bit");

  a_strobe_from_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_SQ_X)
    else $error("result strobe without finishing the loop");

endmodule

>>> src/fibmp_dp.sv
module fibmp_dp (
  input  logic                                clk,
  input  fibmp_pkg::cmd_t                     cmd,
  input  logic [fibmp_pkg::INDEX_BITS-1:0]    in_index,
  output logic [fibmp_pkg::VALUE_BITS-1:0]    out_value
);

  // power held as a = F(k+1), b = F(k); the matrix is [[a,b],[b,a-b]]
  logic [fibmp_pkg::INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [fibmp_pkg::VALUE_BITS-1:0] a_r, a_nxt;
  logic [fibmp_pkg::VALUE_BITS-1:0] b_r, b_nxt;
  logic [fibmp_pkg::VALUE_BITS-1:0] aa_r, aa_nxt;
  logic [fibmp_pkg::VALUE_BITS-1:0] bb_r, bb_nxt;
  logic [fibmp_pkg::VALUE_BITS-1:0] mul_x, mul_y, prod;
  logic [fibmp_pkg::VALUE_BITS-1:0] two_a_b, a_sq, b_sq;

  // F(2k) = F(k) * (2F(k+1) - F(k))
  assign two_a_b = {a_r[fibmp_pkg::VALUE_BITS-2:0], 1'b0} - b_r;

  always_comb begin
    mul_x = a_r;
    mul_y = a_r;
    unique case (cmd.op)
      fibmp_pkg::MUL_AA: begin
        mul_x = a_r;
        mul_y = a_r;
      end
      fibmp_pkg::MUL_BB: begin
        mul_x = b_r;
        mul_y = b_r;
      end
      fibmp_pkg::MUL_BX: begin
        mul_x = b_r;
        mul_y = two_a_b;
      end
      default: begin
        mul_x = a_r;
        mul_y = a_r;
      end
    endcase
  end

  // shared multiplier, low half only since values wrap
  assign prod = mul_x * mul_y;

  assign a_sq = aa_r + bb_r;
  assign b_sq = prod;

  always_comb begin
    idx_nxt = idx_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    aa_nxt  = aa_r;
    bb_nxt  = bb_r;
    if (cmd.load) begin
      idx_nxt = in_index;
      a_nxt   = fibmp_pkg::VALUE_BITS'(1);
      b_nxt   = '0;
    end else begin
      unique case (cmd.op)
        fibmp_pkg::MUL_AA: aa_nxt = prod;
        fibmp_pkg::MUL_BB: bb_nxt = prod;
        fibmp_pkg::MUL_BX: begin
          // set bit: one more step by the base matrix, (a,b) -> (a+b,a)
          if (idx_r[fibmp_pkg::INDEX_BITS-1]) begin
            a_nxt = a_sq + b_sq;
            b_nxt = a_sq;
          end else begin
            a_nxt = a_sq;
            b_nxt = b_sq;
          end
          idx_nxt = {idx_r[fibmp_pkg::INDEX_BITS-2:0], 1'b0};
        end
        default: begin
          a_nxt = a_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    aa_r  <= aa_nxt;
    bb_r  <= bb_nxt;
  end

  assign out_value = a_r;

endmodule

>>> src/fibonacci_by_matrix_power.sv
// channel   ports                      transfer when
// input     start, busy, in_index      start high and busy low at a rising edge
// result    out_valid, out_value       out_valid high at a rising edge
//
// three steps per index bit on one 32x32 multiplier: a^2, b^2, b*(2a-b)
// busy drops in the out_valid cycle, so the next start can be taken there
// synchronous active-low reset returns to idle with no result pending
// out_valid lasts one cycle; the receiver cannot stall it
module fibonacci_by_matrix_power (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [fibmp_pkg::INDEX_BITS-1:0] in_index,
  output logic                             out_valid,
  output logic [fibmp_pkg::VALUE_BITS-1:0] out_value
);

  fibmp_pkg::cmd_t cmd;

  fibmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fibmp_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_index  (in_index),
    .out_value (out_value)
  );

endmodule
